### hdl/ldp_pkg.sv
// Shared types, character constants and helper functions for the line directive parser.
package ldp_pkg;

	localparam int unsigned LINE_NUMBER_BITS_DEF = 32;
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_line;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  name_byte;
		logic        is_directive;
		logic [31:0] line_number;
		logic        has_file_name;
		logic        last;
	} out_item_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// characters of the "line" keyword
	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h6c;
			2'd1: r = 8'h69;
			2'd2: r = 8'h6e;
			default: r = 8'h65;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] decode_escape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h61: r = 8'h07;
			8'h62: r = 8'h08;
			8'h65, 8'h45: r = CH_ESC;
			8'h66: r = 8'h0c;
			8'h6e: r = 8'h0a;
			8'h72: r = 8'h0d;
			8'h74: r = 8'h09;
			8'h76: r = 8'h0b;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

### hdl/ldp_parser.sv
// Per-byte parse state and next-state logic; yields up to two results per byte.
module ldp_parser #(
	parameter int unsigned LINE_NUMBER_BITS = ldp_pkg::LINE_NUMBER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ldp_pkg::in_item_t item,
	output logic [1:0]        res_cnt,
	output ldp_pkg::out_item_t res0,
	output ldp_pkg::out_item_t res1
);
	import ldp_pkg::*;

	localparam int unsigned NB = LINE_NUMBER_BITS;

	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_HASHWS  = 4'd1,
		PH_KEYWORD = 4'd2,
		PH_AFTERKW = 4'd3,
		PH_KWWS    = 4'd4,
		PH_DIGITS  = 4'd5,
		PH_TRAILWS = 4'd6,
		PH_FNAME   = 4'd7,
		PH_TAIL    = 4'd8,
		PH_FAIL    = 4'd9
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [1:0]      kidx_q, kidx_d;
	logic [NB-1:0]   acc_q, acc_d;
	logic            ovf_q, ovf_d;
	logic            esc_q, esc_d;
	logic            file_q, file_d;

	logic [7:0]      c;
	logic            eol;
	logic            do_digit;
	logic [NB+3:0]   acc_x10;
	logic            ovf_hit;
	logic            emit;
	logic [7:0]      nb;
	logic            ok;
	out_item_t       name_res, sum_res;

	assign c   = item.data_byte;
	assign eol = item.end_of_line;

	// 10*acc + d; anything in the top four bits is past the number width
	assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NB+4)'(c - CH_ZERO);
	assign ovf_hit = |acc_x10[NB+3:NB];

	always_comb begin
		phase_d  = phase_q;
		kidx_d   = kidx_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		esc_d    = esc_q;
		file_d   = file_q;
		do_digit = 1'b0;
		emit     = 1'b0;
		nb       = c;

		case (phase_q)
			PH_LEAD: begin
				if (c == CH_HASH) phase_d = PH_HASHWS;
				else if (!is_ws(c)) phase_d = PH_FAIL;
			end
			PH_HASHWS: begin
				if (!is_ws(c)) begin
					if (c == kw_char(2'd0)) begin
						phase_d = PH_KEYWORD;
						kidx_d  = 2'd1;
					end else if (is_digit(c)) begin
						phase_d  = PH_DIGITS;
						do_digit = 1'b1;
					end else begin
						phase_d = PH_FAIL;
					end
				end
			end
			PH_KEYWORD: begin
				if (c == kw_char(kidx_q)) begin
					if (kidx_q == 2'd3) begin
						phase_d = PH_AFTERKW;
						kidx_d  = 2'd0;
					end else begin
						kidx_d = kidx_q + 2'd1;
					end
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_AFTERKW: phase_d = is_ws(c) ? PH_KWWS : PH_FAIL;
			PH_KWWS: begin
				if (!is_ws(c)) begin
					if (is_digit(c)) begin
						phase_d  = PH_DIGITS;
						do_digit = 1'b1;
					end else begin
						phase_d = PH_FAIL;
					end
				end
			end
			PH_DIGITS: begin
				if (is_digit(c)) do_digit = 1'b1;
				else if (is_ws(c)) phase_d = PH_TRAILWS;
				else if (c == CH_QUOTE) begin
					phase_d = PH_FNAME;
					file_d  = 1'b1;
				end else phase_d = PH_TAIL;
			end
			PH_TRAILWS: begin
				if (!is_ws(c)) begin
					if (c == CH_QUOTE) begin
						phase_d = PH_FNAME;
						file_d  = 1'b1;
					end else phase_d = PH_TAIL;
				end
			end
			PH_FNAME: begin
				if (esc_q) begin
					esc_d = 1'b0;
					emit  = 1'b1;
					nb    = decode_escape(c);
				end else if (c == CH_QUOTE) begin
					phase_d = PH_TAIL;
				end else if (c == CH_BSL && !eol) begin
					esc_d = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			PH_TAIL: ;
			default: phase_d = PH_FAIL;
		endcase

		if (do_digit) begin
			if (ovf_hit) begin
				ovf_d   = 1'b1;
				phase_d = PH_FAIL;
			end else begin
				acc_d = acc_x10[NB-1:0];
			end
		end

		ok = !ovf_d && (phase_d inside {PH_DIGITS, PH_TRAILWS, PH_FNAME, PH_TAIL});

		name_res = '{result_kind: KIND_NAME, name_byte: nb, is_directive: 1'b0,
			line_number: 32'd0, has_file_name: 1'b0, last: !eol};
		sum_res = '{result_kind: KIND_SUMMARY, name_byte: 8'd0, is_directive: ok,
			line_number: ok ? 32'(acc_d) : 32'd0, has_file_name: ok && file_d,
			last: 1'b1};

		// summary goes to the front when no name byte precedes it
		res0    = emit ? name_res : sum_res;
		res1    = sum_res;
		res_cnt = 2'(emit) + 2'(eol);

		if (eol) begin
			phase_d = PH_LEAD;
			kidx_d  = 2'd0;
			acc_d   = '0;
			ovf_d   = 1'b0;
			esc_d   = 1'b0;
			file_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			kidx_q  <= 2'd0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			esc_q   <= 1'b0;
			file_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			kidx_q  <= kidx_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			esc_q   <= esc_d;
			file_q  <= file_d;
		end
	end

endmodule

### hdl/ldp_result_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one per transaction.
module ldp_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  ldp_pkg::out_item_t  push0,
	input  ldp_pkg::out_item_t  push1,
	output logic                room2,
	output logic                out_valid,
	input  logic                out_ready,
	output ldp_pkg::out_item_t  out_data
);
	import ldp_pkg::*;

	out_item_t              mem [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wp_q, rp_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic                   pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rp_q];
	assign room2     = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem[wp_q] <= push0;
		if (push_cnt == 2'd2) mem[wp_q + RES_PTR_W'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + RES_PTR_W'(push_cnt);
			if (pop) rp_q <= rp_q + RES_PTR_W'(1);
			cnt_q <= cnt_q + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
		end
	end

endmodule

### hdl/line_directive_parser_core.sv
// Line directive parser top level: input register, byte parser and result queue.
// A byte in the input register is parsed and its results queued once the queue has room
// for two. Throughput: one byte per cycle while that room holds; a byte that yields a
// name byte and the summary occupies the output for two transactions, set by the single-result output port.
// Reset clears the parse state and empties the result queue.
module line_directive_parser_core #(
	parameter int unsigned LINE_NUMBER_BITS = ldp_pkg::LINE_NUMBER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ldp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ldp_pkg::out_item_t out_data
);
	import ldp_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       adv;
	logic       room2;
	logic [1:0] res_cnt;
	out_item_t  res0, res1;

	assign adv      = valid_s1 && room2;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
	end

	ldp_parser #(
		.LINE_NUMBER_BITS(LINE_NUMBER_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.item    (item_s1),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	ldp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (adv ? res_cnt : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### verif/line_directive_parser_checker.sv
// Checker for the line directive parser: predicts results from accepted bytes and compares.
module line_directive_parser_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  ldp_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  ldp_pkg::out_item_t out_data,
	output int                 fails,
	output int                 pending,
	output int                 results,
	output int                 directives
);
	timeunit 1ns;
	timeprecision 1ps;
	import ldp_pkg::*;

	typedef enum logic [3:0] {
		P_LEAD, P_HASH_WS, P_KEYWORD, P_KW_END, P_KW_WS,
		P_DIGITS, P_TRAIL_WS, P_NAME, P_TAIL, P_BAD
	} scan_phase_t;

	localparam logic [31:0] KEYWORD = "line";

	scan_phase_t phase;
	logic [1:0]  kw_pos;
	logic [31:0] lnum_acc;
	logic        lnum_ovf;
	logic        esc_armed;
	logic        quoted;
	out_item_t   awaited_results[$];

	function automatic logic blank(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d};
	endfunction

	function automatic logic numeral(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// C escapes a b e E f n r t v; anything else stands for itself
	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			8'h61: return 8'h07;
			8'h62: return 8'h08;
			8'h65, 8'h45: return CH_ESC;
			8'h66: return 8'h0c;
			8'h6e: return 8'h0a;
			8'h72: return 8'h0d;
			8'h74: return 8'h09;
			8'h76: return 8'h0b;
			default: return c;
		endcase
	endfunction

	function automatic int field_diff(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic clear_state();
		phase = P_LEAD;
		kw_pos = 2'd0;
		lnum_acc = 32'd0;
		lnum_ovf = 1'b0;
		esc_armed = 1'b0;
		quoted = 1'b0;
	endtask

	task automatic count_digit(input logic [7:0] b);
		logic [63:0] d;
		d = 64'(b - CH_ZERO);
		if (64'(lnum_acc) > (64'hffff_ffff - d) / 10) begin
			lnum_ovf = 1'b1;
			phase = P_BAD;
		end else begin
			lnum_acc = 32'(64'(lnum_acc) * 10 + d);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic eol);
		out_item_t r [2];
		int n;
		logic ok;
		n = 0;
		r[0] = '0;
		r[1] = '0;
		case (phase)
			P_LEAD: begin
				if (b == CH_HASH) phase = P_HASH_WS;
				else if (!blank(b)) phase = P_BAD;
			end
			P_HASH_WS: begin
				if (!blank(b)) begin
					if (b == KEYWORD[31:24]) begin
						phase = P_KEYWORD;
						kw_pos = 2'd1;
					end else if (numeral(b)) begin
						phase = P_DIGITS;
						count_digit(b);
					end else begin
						phase = P_BAD;
					end
				end
			end
			P_KEYWORD: begin
				if (b == KEYWORD[8 * (3 - kw_pos) +: 8]) begin
					if (kw_pos == 2'd3) begin
						phase = P_KW_END;
						kw_pos = 2'd0;
					end else begin
						kw_pos = kw_pos + 2'd1;
					end
				end else begin
					phase = P_BAD;
				end
			end
			P_KW_END: phase = blank(b) ? P_KW_WS : P_BAD;
			P_KW_WS: begin
				if (!blank(b)) begin
					if (numeral(b)) begin
						phase = P_DIGITS;
						count_digit(b);
					end else begin
						phase = P_BAD;
					end
				end
			end
			P_DIGITS: begin
				if (numeral(b)) count_digit(b);
				else if (blank(b)) phase = P_TRAIL_WS;
				else if (b == CH_QUOTE) begin
					phase = P_NAME;
					quoted = 1'b1;
				end else phase = P_TAIL;
			end
			P_TRAIL_WS: begin
				if (b == CH_QUOTE) begin
					phase = P_NAME;
					quoted = 1'b1;
				end else if (!blank(b)) phase = P_TAIL;
			end
			P_NAME: begin
				if (esc_armed) begin
					esc_armed = 1'b0;
					r[n].result_kind = KIND_NAME;
					r[n].name_byte = unescape(b);
					n++;
				end else if (b == CH_QUOTE) begin
					phase = P_TAIL;
				end else if (b == CH_BSL && !eol) begin
					esc_armed = 1'b1;
				end else begin
					r[n].result_kind = KIND_NAME;
					r[n].name_byte = b;
					n++;
				end
			end
			P_TAIL: ;
			default: phase = P_BAD;
		endcase
		if (eol) begin
			ok = !lnum_ovf && (phase inside {P_DIGITS, P_TRAIL_WS, P_NAME, P_TAIL});
			r[n].result_kind = KIND_SUMMARY;
			r[n].is_directive = ok;
			r[n].line_number = ok ? lnum_acc : 32'd0;
			r[n].has_file_name = ok && quoted;
			n++;
			clear_state();
		end
		if (n > 0) r[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) awaited_results.insert(awaited_results.size(), r[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		int bad;
		if (!arst_n) begin
			clear_state();
			awaited_results.delete();
			fails <= 0;
			pending <= 0;
			results <= 0;
			directives <= 0;
		end else begin
			// input first, so a transaction's expectations exist before any output check
			if (in_valid && in_ready) parse_byte(in_data.data_byte, in_data.end_of_line);
			if (out_valid && out_ready) begin
				bad = 0;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0d, name_byte 0x%0h, line_number %0d",
						out_data.result_kind, out_data.name_byte, out_data.line_number);
					bad = 1;
				end else begin
					want = awaited_results.pop_front();
					bad += field_diff("result_kind", 32'(want.result_kind),
						32'(out_data.result_kind));
					bad += field_diff("name_byte", 32'(want.name_byte),
						32'(out_data.name_byte));
					bad += field_diff("is_directive", 32'(want.is_directive),
						32'(out_data.is_directive));
					bad += field_diff("line_number", want.line_number, out_data.line_number);
					bad += field_diff("has_file_name", 32'(want.has_file_name),
						32'(out_data.has_file_name));
					bad += field_diff("last", 32'(want.last), 32'(out_data.last));
				end
				if (bad != 0) fails <= fails + 1;
				results <= results + 1;
				if (out_data.result_kind == KIND_SUMMARY && out_data.is_directive)
					directives <= directives + 1;
			end
			pending <= awaited_results.size();
		end
	end

endmodule

### verif/line_directive_parser_core_tb.sv
// Testbench top for the line directive parser: clock, reset, line stimulus and verdict.
module line_directive_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ldp_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int fails;
	int pending;
	int results;
	int directives;

	logic [7:0] line_buf[$];
	int lines_sent = 0;
	int bytes_sent = 0;
	bit send_quiet = 1'b0;
	bit take_quiet = 1'b0;

	line_directive_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	line_directive_parser_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fails(fails),
		.pending(pending),
		.results(results),
		.directives(directives)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stall before each transaction, with quiet stretches
	initial begin : receiver
		int hold;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			hold = take_quiet ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if ($urandom_range(0, 29) == 0) take_quiet = !take_quiet;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_ws(input int lo, input int hi);
		logic [7:0] pick [5];
		int cnt;
		pick = '{8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d};
		cnt = $urandom_range(lo, hi);
		repeat (cnt) add_byte(pick[$urandom_range(0, 4)]);
	endtask

	task automatic send_line();
		int gap;
		for (int i = 0; i < line_buf.size(); i++) begin
			gap = send_quiet ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data <= '{data_byte: line_buf[i], end_of_line: (i == line_buf.size() - 1)};
			do @(posedge clk); while (!in_ready);
			bytes_sent++;
		end
		lines_sent++;
		line_buf.delete();
		if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
	endtask

	// hold the input off until every predicted result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// mostly well-formed directives with random content; noise and mutated lines otherwise
	task automatic build_random_line();
		string esc_set;
		int len;
		int keep;
		esc_set = "abeEfnrtv\"\\";
		if ($urandom_range(0, 3) == 0) begin
			len = $urandom_range(1, 6);
			if ($urandom_range(0, 1) == 0) add_byte(CH_HASH);
			repeat (len) add_byte(8'($urandom_range(0, 255)));
		end else begin
			add_ws(0, 2);
			add_byte(CH_HASH);
			add_ws(0, 2);
			case ($urandom_range(0, 9))
				5, 6, 7: begin
					add_str("line");
					add_ws(1, 2);
				end
				8: add_str("line");
				9: add_str("lixe ");
				default: ;
			endcase
			case ($urandom_range(0, 5))
				0, 1: repeat ($urandom_range(1, 3)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				2: repeat (10) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				3: add_str("4294967295");
				4: add_str("4294967296");
				default: begin
					repeat ($urandom_range(1, 11)) add_byte(CH_ZERO);
					add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				end
			endcase
			if ($urandom_range(0, 2) != 0) begin
				add_ws(0, 2);
				add_byte(CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 4) == 0) begin
						add_byte(CH_BSL);
						if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(0, 255)));
						else add_byte(esc_set[$urandom_range(0, 10)]);
					end else begin
						add_byte(8'($urandom_range(0, 255)));
					end
				end
				if ($urandom_range(0, 3) != 0) add_byte(CH_QUOTE);
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 5) == 0)
				line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0) begin
				keep = $urandom_range(1, line_buf.size());
				line_buf = line_buf[0:keep - 1];
			end
		end
	endtask

	initial begin : stimulus
		in_valid <= 1'b0;
		in_data <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// no hash, smallest and largest byte values
		add_byte(8'h00);
		add_byte(8'hff);
		send_line();
		// backslash as the final byte of a quoted name
		add_str("#9\"\\");
		send_line();
		// text straight after the number
		add_str("#0x");
		send_line();
		// keyword with no whitespace after it
		add_str("#line7");
		send_line();
		// unknown escape inside a name that is never closed
		add_str("\t# 1 \"\\q");
		send_line();
		drain();

		while (bytes_sent < 780) begin
			build_random_line();
			send_line();
			if ($urandom_range(0, 24) == 0) drain();
		end
		drain();
		repeat (10) @(posedge clk);

		$display("Sent %0d lines (%0d bytes) under random gaps and stalls; %0d results checked.",
			lines_sent, bytes_sent, results);
		$display("Lines recognised as directives: %0d.", directives);
		if (fails == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### line_directive_parser_core.f
hdl/ldp_pkg.sv
hdl/ldp_parser.sv
hdl/ldp_result_fifo.sv
hdl/line_directive_parser_core.sv
verif/line_directive_parser_checker.sv
verif/line_directive_parser_core_tb.sv
